/* design/sscr_pkg.sv */
// ----------------------------------------------------------------------------
// sscr_pkg
// Shared types and constants for the S-curve stepper speed ramp.
// ----------------------------------------------------------------------------
package sscr_pkg;

  localparam int unsigned SPEED_W  = 16;
  localparam int unsigned FREQ_W   = 20;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned DIVS_W   = 8;
  localparam int unsigned ACC_W    = 8;
  localparam int unsigned IDX_W    = 2;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 24;
  localparam int unsigned DIV_STEPS   = SPEED_W;
  localparam int unsigned DIV_CNT_W   = $clog2(DIV_STEPS);

  localparam logic [IDX_W-1:0] CFG_MIN_FREQ     = 2'd0;
  localparam logic [IDX_W-1:0] CFG_SPLIT_DIV    = 2'd1;
  localparam logic [IDX_W-1:0] CFG_ACCEL_INC    = 2'd2;

  localparam logic [SPEED_W-1:0] MIN_FREQ_RST   = 16'd100;
  localparam logic [DIVS_W-1:0]  SPLIT_DIV_RST  = 8'd7;
  localparam logic [ACC_W-1:0]   ACCEL_INC_RST  = 8'd10;

  localparam logic CMD_TARGET  = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  localparam logic [1:0] PHASE_NONE = 2'd0;
  localparam logic [1:0] PHASE_UP   = 2'd1;
  localparam logic [1:0] PHASE_DOWN = 2'd2;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_UP,
    SEQ_DOWN,
    SEQ_SETTLE
  } seq_phase_t;

  typedef enum logic [1:0] {
    ST_IN,
    ST_DIV,
    ST_STEP,
    ST_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic accept;
    logic setup;
    logic step;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_status_t;

endpackage

/* design/sscr_div.sv */
// ----------------------------------------------------------------------------
// sscr_div
// Restoring divider, one quotient bit per cycle. A zero divisor acts as one.
// ----------------------------------------------------------------------------
module sscr_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [sscr_pkg::SPEED_W-1:0] dividend,
  input  logic [sscr_pkg::DIVS_W-1:0]  divisor,
  output logic                         done,
  output logic [sscr_pkg::SPEED_W-1:0] quotient
);
  import sscr_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIVS_W-1:0]    rem_r, rem_nxt;
  logic [DIVS_W-1:0]    dvs_r, dvs_nxt;
  logic [SPEED_W-1:0]   quo_r, quo_nxt;
  logic [DIVS_W:0]      trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    trial    = {rem_r, quo_r[SPEED_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = (divisor == '0) ? DIVS_W'(1) : divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = DIVS_W'(trial - {1'b0, dvs_r});
        quo_nxt = {quo_r[SPEED_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DIVS_W-1:0];
        quo_nxt = {quo_r[SPEED_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

/* design/sscr_dp.sv */
// ----------------------------------------------------------------------------
// sscr_dp
// Ramp datapath: configuration, ramp state, step arithmetic, output register.
// ----------------------------------------------------------------------------
module sscr_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sscr_pkg::dp_cmd_t             cmd,
  output sscr_pkg::dp_status_t          status,
  input  logic                          in_cmd,
  input  logic [sscr_pkg::SPEED_W-1:0]  in_target,
  input  logic                          in_dir,
  input  logic                          cfg_we,
  input  logic [sscr_pkg::IDX_W-1:0]    cfg_idx,
  input  logic [sscr_pkg::CFG_W-1:0]    cfg_wdata,
  output logic [sscr_pkg::FREQ_W-1:0]   out_freq,
  output logic                          out_dir,
  output logic                          out_last,
  output logic [1:0]                    out_phase
);
  import sscr_pkg::*;

  logic [SPEED_W-1:0] min_freq_r;
  logic [DIVS_W-1:0]  split_div_r;
  logic [ACC_W-1:0]   accel_r;

  logic [SPEED_W-1:0] cur_r, cur_nxt;
  logic               dir_r, dir_nxt;
  logic [SPEED_W-1:0] tgt_r, tgt_nxt;
  logic [WORD_W-1:0]  ramp_r, ramp_nxt;
  logic [WORD_W-1:0]  inc_r, inc_nxt;
  logic [WORD_W-1:0]  iter_r, iter_nxt;
  logic [WORD_W-1:0]  sq_r, sq_nxt;
  logic [SPEED_W-1:0] split_r, split_nxt;
  logic [WORD_W-1:0]  taper_r, taper_nxt;
  logic               armed_r, armed_nxt;
  seq_phase_t         seq_r, seq_nxt;
  logic               is_cmd_r, is_cmd_nxt;

  logic [FREQ_W-1:0]  res_freq_r, res_freq_nxt;
  logic               res_dir_r, res_dir_nxt;
  logic               res_last_r, res_last_nxt;
  logic [1:0]         res_phase_r, res_phase_nxt;

  logic [FREQ_W-1:0]  out_freq_r;
  logic               out_dir_r;
  logic               out_last_r;
  logic [1:0]         out_phase_r;

  logic               div_start;
  logic               div_done;
  logic [SPEED_W-1:0] div_dividend;
  logic [SPEED_W-1:0] quo;

  logic [WORD_W-1:0]  acc_ext;
  logic [WORD_W-1:0]  acc_w;
  logic [WORD_W-1:0]  rv;
  logic [SPEED_W-1:0] floor_v;
  logic [SPEED_W-1:0] ev;
  logic               do_end;
  logic               do_iter;
  logic [WORD_W-1:0]  emit_f;
  logic               emit_last;
  logic [1:0]         emit_ph;

  assign div_start    = cmd.accept && (in_cmd == CMD_TARGET);
  assign div_dividend = (cur_r > in_target) ? (cur_r - in_target) : (in_target - cur_r);

  sscr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (split_div_r),
    .done     (div_done),
    .quotient (quo)
  );

  assign status.div_done = div_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_freq_r   <= MIN_FREQ_RST;
      split_div_r  <= SPLIT_DIV_RST;
      accel_r      <= ACCEL_INC_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_MIN_FREQ:   min_freq_r   <= cfg_wdata;
        CFG_SPLIT_DIV:  split_div_r  <= cfg_wdata[DIVS_W-1:0];
        CFG_ACCEL_INC:  accel_r      <= cfg_wdata[ACC_W-1:0];
        default: ;
      endcase
    end
  end

  assign acc_ext = {{(WORD_W-ACC_W){1'b0}}, accel_r};
  assign floor_v = (tgt_r < min_freq_r) ? min_freq_r : tgt_r;

  always_comb begin
    cur_nxt    = cur_r;
    dir_nxt    = dir_r;
    tgt_nxt    = tgt_r;
    ramp_nxt   = ramp_r;
    inc_nxt    = inc_r;
    iter_nxt   = iter_r;
    sq_nxt     = sq_r;
    split_nxt  = split_r;
    taper_nxt  = taper_r;
    armed_nxt  = armed_r;
    seq_nxt    = seq_r;
    is_cmd_nxt = is_cmd_r;
    res_freq_nxt  = res_freq_r;
    res_dir_nxt   = res_dir_r;
    res_last_nxt  = res_last_r;
    res_phase_nxt = res_phase_r;
    acc_w     = acc_ext;
    rv        = ramp_r;
    ev        = tgt_r;
    do_end    = 1'b0;
    do_iter   = 1'b0;
    emit_f    = '0;
    emit_last = 1'b0;
    emit_ph   = PHASE_NONE;

    if (cmd.accept) begin
      is_cmd_nxt = (in_cmd == CMD_TARGET);
      if (in_cmd == CMD_TARGET) begin
        tgt_nxt   = in_target;
        dir_nxt   = in_dir;
        inc_nxt   = WORD_W'(1);
        iter_nxt  = '0;
        sq_nxt    = '0;
        taper_nxt = '0;
        armed_nxt = 1'b0;
      end
    end

    if (cmd.setup) begin
      if (cur_r < tgt_r) begin
        split_nxt = cur_r + quo;
        ramp_nxt  = {{(WORD_W-SPEED_W){1'b0}}, (cur_r < min_freq_r) ? min_freq_r : cur_r};
        seq_nxt   = SEQ_UP;
      end else if (tgt_r < cur_r) begin
        split_nxt = cur_r - quo;
        ramp_nxt  = {{(WORD_W-SPEED_W){1'b0}}, cur_r};
        seq_nxt   = SEQ_DOWN;
      end else begin
        seq_nxt   = SEQ_IDLE;
      end
    end

    if (cmd.step) begin
      if (is_cmd_r && (seq_r == SEQ_IDLE)) begin
        emit_f    = {{(WORD_W-SPEED_W){1'b0}}, tgt_r};
        emit_last = 1'b1;
      end else begin
        case (seq_r)
          SEQ_UP: begin
            if (!(ramp_r < {{(WORD_W-SPEED_W){1'b0}}, tgt_r})) begin
              do_end = 1'b1;
              ev     = tgt_r;
            end else begin
              rv       = ramp_r + inc_r;
              ramp_nxt = rv;
              if (rv < {{(WORD_W-SPEED_W){1'b0}}, split_r}) begin
                inc_nxt = inc_r + acc_w;
              end else if (!armed_r) begin
                taper_nxt = {{(WORD_W-SPEED_W){1'b0}}, tgt_r} - (sq_r >> 1);
                armed_nxt = 1'b1;
              end else if (taper_r < rv) begin
                inc_nxt = inc_r - acc_w;
              end
              do_iter = 1'b1;
              emit_f  = rv;
              emit_ph = PHASE_UP;
            end
          end
          SEQ_DOWN: begin
            if (!({{(WORD_W-SPEED_W){1'b0}}, floor_v} < ramp_r)) begin
              do_end = 1'b1;
              ev     = floor_v;
            end else if (ramp_r <= inc_r) begin
              do_end = 1'b1;
              ev     = '0;
            end else begin
              rv       = ramp_r - inc_r;
              ramp_nxt = rv;
              do_iter  = 1'b1;
              emit_f   = rv;
              emit_ph  = PHASE_DOWN;
              if ({{(WORD_W-SPEED_W){1'b0}}, split_r} < rv) begin
                inc_nxt = inc_r + acc_w;
              end else if (!armed_r) begin
                taper_nxt = {{(WORD_W-SPEED_W){1'b0}}, floor_v} + (sq_r >> 1);
                armed_nxt = 1'b1;
              end else if (rv < taper_r) begin
                if (inc_r <= acc_w) begin
                  do_end  = 1'b1;
                  do_iter = 1'b0;
                  ev      = floor_v;
                end else begin
                  inc_nxt = inc_r - acc_w;
                end
              end
            end
          end
          SEQ_SETTLE: begin
            cur_nxt   = tgt_r;
            seq_nxt   = SEQ_IDLE;
            emit_f    = {{(WORD_W-SPEED_W){1'b0}}, tgt_r};
            emit_last = 1'b1;
          end
          default: begin
            seq_nxt = SEQ_IDLE;
            emit_f  = {{(WORD_W-SPEED_W){1'b0}}, cur_r};
          end
        endcase
      end

      if (do_iter) begin
        iter_nxt = iter_r + WORD_W'(1);
        sq_nxt   = sq_r + {iter_r[WORD_W-2:0], 1'b1};
      end

      if (do_end) begin
        emit_f  = {{(WORD_W-SPEED_W){1'b0}}, ev};
        emit_ph = PHASE_NONE;
        if (ev == tgt_r) begin
          cur_nxt   = tgt_r;
          seq_nxt   = SEQ_IDLE;
          emit_last = 1'b1;
        end else begin
          seq_nxt   = SEQ_SETTLE;
          emit_last = 1'b0;
        end
      end

      res_freq_nxt  = (|emit_f[WORD_W-1:FREQ_W]) ? '1 : emit_f[FREQ_W-1:0];
      res_dir_nxt   = dir_r;
      res_last_nxt  = emit_last;
      res_phase_nxt = emit_ph;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r    <= '0;
      dir_r    <= 1'b0;
      tgt_r    <= '0;
      ramp_r   <= '0;
      inc_r    <= WORD_W'(1);
      iter_r   <= '0;
      sq_r     <= '0;
      split_r  <= '0;
      taper_r  <= '0;
      armed_r  <= 1'b0;
      seq_r    <= SEQ_IDLE;
      is_cmd_r <= 1'b0;
    end else begin
      cur_r    <= cur_nxt;
      dir_r    <= dir_nxt;
      tgt_r    <= tgt_nxt;
      ramp_r   <= ramp_nxt;
      inc_r    <= inc_nxt;
      iter_r   <= iter_nxt;
      sq_r     <= sq_nxt;
      split_r  <= split_nxt;
      taper_r  <= taper_nxt;
      armed_r  <= armed_nxt;
      seq_r    <= seq_nxt;
      is_cmd_r <= is_cmd_nxt;
    end
    res_freq_r  <= res_freq_nxt;
    res_dir_r   <= res_dir_nxt;
    res_last_r  <= res_last_nxt;
    res_phase_r <= res_phase_nxt;
    if (cmd.out_load) begin
      out_freq_r  <= res_freq_r;
      out_dir_r   <= res_dir_r;
      out_last_r  <= res_last_r;
      out_phase_r <= res_phase_r;
    end
  end

  assign out_freq  = out_freq_r;
  assign out_dir   = out_dir_r;
  assign out_last  = out_last_r;
  assign out_phase = out_phase_r;

endmodule

/* design/sscr_ctrl.sv */
// ----------------------------------------------------------------------------
// sscr_ctrl
// Sequencer: input handshake, divider wait, step issue and output valid.
// ----------------------------------------------------------------------------
module sscr_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_cmd,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sscr_pkg::dp_cmd_t    cmd,
  input  sscr_pkg::dp_status_t status
);
  import sscr_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    in_ready     = 1'b0;
    case (state_r)
      ST_IN: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = (in_cmd == CMD_TARGET) ? ST_DIV : ST_STEP;
        end
      end
      ST_DIV: begin
        if (status.div_done) begin
          cmd.setup = 1'b1;
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        cmd.step  = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IN;
        end
      end
      default: state_nxt = ST_IN;
    endcase

    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IN;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* design/stepper_s_curve_speed_ramp_top.sv */
// ----------------------------------------------------------------------------
// stepper_s_curve_speed_ramp_top
// S-curve step-frequency ramp generator for a stepper motor.
// ----------------------------------------------------------------------------
// Input stream: in_tuser is the item kind (0 new target, 1 advance), in_tdata
// carries target speed and direction. Every input transaction yields exactly
// one output transaction: pulse frequency and direction in out_tdata, ramp
// phase in out_tuser, out_tlast on the final value of a command.
// A target command starts the restoring divider that places the split point,
// then takes one step of the ramp datapath once the divider is done, and
// loads the output register. An advance skips the divider: one step of the
// ramp datapath plus output load.
// One item is processed at a time; the next input is taken once the previous
// result sits in the output register, even if the receiver has not taken it.
// A stalled receiver holds the output register and blocks after one more item.
// The cfg channel is always ready; writes take effect on the next cycle. The
// user must make writes only while the block is idle; the block itself does
// not enforce this. Out-of-range indexes are ignored.
// Reset (rst_n low, synchronous) clears the ramp to speed zero, idle, with
// minimum frequency 100, split divisor 7, acceleration increment 10.
// ----------------------------------------------------------------------------
module stepper_s_curve_speed_ramp_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [15:0] target_speed, [16] direction, [23:17] zero
  input  logic [sscr_pkg::IN_TDATA_W-1:0]   in_tdata,
  // [0] cmd
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [19:0] pulse_freq, [20] dir_out, [23:21] zero
  output logic [sscr_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // [1:0] ramp_phase
  output logic [1:0]                        out_tuser,
  output logic                              out_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sscr_pkg::IDX_W-1:0]        cfg_index,
  input  logic [sscr_pkg::CFG_W-1:0]        cfg_data
);
  import sscr_pkg::*;

  dp_cmd_t            dp_cmd;
  dp_status_t         dp_status;
  logic [FREQ_W-1:0]  freq;
  logic               dir_o;

  assign cfg_ready = 1'b1;

  sscr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_cmd    (in_tuser),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .cmd       (dp_cmd),
    .status    (dp_status)
  );

  sscr_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (dp_cmd),
    .status    (dp_status),
    .in_cmd    (in_tuser),
    .in_target (in_tdata[SPEED_W-1:0]),
    .in_dir    (in_tdata[SPEED_W]),
    .cfg_we    (cfg_valid),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .out_freq  (freq),
    .out_dir   (dir_o),
    .out_last  (out_tlast),
    .out_phase (out_tuser)
  );

  assign out_tdata = {{(OUT_TDATA_W-FREQ_W-1){1'b0}}, dir_o, freq};

endmodule
